FILE: sv/zbps_pkg.sv
// ----------------------------------------------------------------------------
// zbps_pkg
// Shared constants and types of the z-buffer point shader.
// ----------------------------------------------------------------------------
`default_nettype none
package zbps_pkg;
    localparam int MAX_WIDTH    = 128;
    localparam int MAX_HEIGHT   = 64;
    localparam int SHADE_LEVELS = 12;
    localparam int STORE_SIZE   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_SIZE);
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int FW_W         = 8;
    localparam int FH_W         = 7;
    localparam int DIM_W        = 11;
    localparam int COORD_W      = 20;
    localparam int SHADE_W      = 4;
    localparam int DEPTH_W      = 16;
    localparam int CELL_W       = SHADE_W + DEPTH_W;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z      = 3'd4;

    localparam logic [1:0] FUNC_PLOT  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [SHADE_W-1:0] SHADE_BG  = SHADE_W'(SHADE_LEVELS);
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7fff;

    typedef struct packed {
        logic                        busy;
        logic signed [DEPTH_W-1:0]   depth;
    } recip_status_t;
endpackage
`default_nettype wire

FILE: sv/zbps_ram.sv
// ----------------------------------------------------------------------------
// zbps_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none
module zbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic                      re,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: sv/zbps_recip.sv
// ----------------------------------------------------------------------------
// zbps_recip
// Inverse depth 2^20 / z, one quotient bit per cycle, saturated to Q4.12.
// ----------------------------------------------------------------------------
`default_nettype none
module zbps_recip (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [16:0]   zsum,
    output zbps_pkg::recip_status_t   status
);
    localparam int QW = 21;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [16:0] dvs_reg, dvs_next;
    logic [16:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic [17:0] rem_sh;
    logic signed [zbps_pkg::DEPTH_W-1:0] sat;

    always_comb begin
        rem_sh    = {rem_reg, (cnt_reg == 5'(QW - 1))};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'(QW - 1);
            dvs_next  = zsum[16] ? 17'(-zsum) : 17'(zsum);
            rem_next  = '0;
            quo_next  = '0;
            neg_next  = zsum[16];
            zero_next = (zsum == '0);
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = 17'(rem_sh - {1'b0, dvs_reg});
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[16:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_comb begin
        priority if (zero_reg) begin
            sat = zbps_pkg::DEPTH_MAX;
        end else if (neg_reg) begin
            sat = (quo_reg > QW'(32768)) ? zbps_pkg::DEPTH_MIN : 16'(-quo_reg);
        end else begin
            sat = (quo_reg > QW'(32767)) ? zbps_pkg::DEPTH_MAX : 16'(quo_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign status.busy  = busy_reg;
    assign status.depth = sat;
endmodule
`default_nettype wire

FILE: sv/zbuffer_point_shader.sv
// ----------------------------------------------------------------------------
// zbuffer_point_shader
// Point rasterizer with a per-pixel shade and inverse-depth frame store.
// ----------------------------------------------------------------------------
// One request at a time. A plot runs the bit-serial inverse-depth divider
// (the shared dot-product multiplier finishes inside that time), then reads
// the frame store and writes back if the new depth is greater; a point out
// of the frame writes nothing. A read reads the store, then waits for the
// result register. A clear sweeps the store one pixel a cycle; a like sweep
// writing depth zero runs after reset, and no request is taken until it ends.
// Configuration writes are taken at any time.
`default_nettype none
module zbuffer_point_shader (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_func,
    input  wire logic signed [15:0] s_vert_x,
    input  wire logic signed [15:0] s_vert_y,
    input  wire logic signed [15:0] s_vert_z,
    input  wire logic signed [15:0] s_mesh_x,
    input  wire logic signed [15:0] s_mesh_y,
    input  wire logic signed [15:0] s_mesh_z,
    input  wire logic signed [15:0] s_norm_x,
    input  wire logic signed [15:0] s_norm_y,
    input  wire logic signed [15:0] s_norm_z,
    input  wire logic [12:0]  s_read_addr,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [3:0]        m_pixel_shade,
    output logic signed [15:0] m_pixel_depth
);
    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_WR    = 3'd4;
    localparam logic [2:0] ST_RDOUT = 3'd5;

    localparam int AW = zbps_pkg::ADDR_W;
    localparam int CW = zbps_pkg::COORD_W;

    logic [2:0] state_reg, state_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic signed [15:0] sweep_depth_reg, sweep_depth_next;

    logic [7:0] fw_reg;
    logic [6:0] fh_reg;
    logic signed [15:0] lx_reg, ly_reg, lz_reg;

    logic signed [CW-1:0] sx_reg, sy_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic [2:0] mul_cnt_reg;
    logic signed [31:0] prod_reg;
    logic signed [35:0] acc_reg;
    logic [AW-1:0] idx_reg;
    logic signed [15:0] newd_reg;

    logic out_valid_reg;
    logic [3:0] out_shade_reg;
    logic signed [15:0] out_depth_reg;

    logic accept;
    logic [zbps_pkg::DIM_W-1:0] w_eff, h_eff;
    logic signed [CW-1:0] sx_in, sy_in;
    logic signed [16:0] zs_in;
    logic out_of_frame;
    logic [zbps_pkg::COL_W-1:0] col;
    logic [zbps_pkg::ROW_W-1:0] row;
    logic [AW-1:0] idx;
    logic signed [15:0] mul_a, mul_b;
    logic signed [39:0] num;
    logic [10:0] shade_raw;
    logic [3:0] shade;

    logic mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [zbps_pkg::CELL_W-1:0] mem_wdata, mem_rdata;
    logic signed [15:0] stored_depth;
    logic out_take;

    zbps_pkg::recip_status_t recip;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign out_take = !out_valid_reg || m_ready;

    always_comb begin
        w_eff = (fw_reg > 8'(zbps_pkg::MAX_WIDTH)) ? zbps_pkg::DIM_W'(zbps_pkg::MAX_WIDTH)
                                                   : zbps_pkg::DIM_W'(fw_reg);
        h_eff = (fh_reg > 7'(zbps_pkg::MAX_HEIGHT)) ? zbps_pkg::DIM_W'(zbps_pkg::MAX_HEIGHT)
                                                    : zbps_pkg::DIM_W'(fh_reg);
        sx_in = CW'(s_vert_x) + CW'(s_mesh_x) + $signed(CW'({w_eff >> 1, 8'd0}));
        sy_in = CW'(s_vert_y) + CW'(s_mesh_y) + $signed(CW'({h_eff >> 1, 9'd0}));
        zs_in = 17'(s_vert_z) + 17'(s_mesh_z);
        out_of_frame = sx_reg[CW-1] || sy_reg[CW-1]
                    || (sx_reg >= $signed(CW'({w_eff, 8'd0})))
                    || (sy_reg >= $signed(CW'({h_eff, 9'd0})));
        col = sx_reg[8 +: zbps_pkg::COL_W];
        row = sy_reg[9 +: zbps_pkg::ROW_W];
        idx = AW'(row) * AW'(w_eff) + AW'(col);
    end

    // share one multiplier over the three normal components
    always_comb begin
        unique case (mul_cnt_reg)
            3'd0:    begin mul_a = nx_reg; mul_b = lx_reg; end
            3'd1:    begin mul_a = ny_reg; mul_b = ly_reg; end
            default: begin mul_a = nz_reg; mul_b = lz_reg; end
        endcase
    end

    always_comb begin
        num = (40'sd268435456 - 40'(acc_reg)) * 40'(zbps_pkg::SHADE_LEVELS);
        shade_raw = 11'(num >>> 29);
        priority if (num <= 40'sd0) begin
            shade = '0;
        end else if (shade_raw > 11'(zbps_pkg::SHADE_LEVELS - 1)) begin
            shade = 4'(zbps_pkg::SHADE_LEVELS - 1);
        end else begin
            shade = shade_raw[3:0];
        end
    end

    assign stored_depth = $signed(mem_rdata[15:0]);

    always_comb begin
        state_next       = state_reg;
        sweep_next       = sweep_reg;
        sweep_depth_next = sweep_depth_reg;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {shade, newd_reg};
        mem_re    = 1'b0;
        mem_raddr = idx;
        unique case (state_reg)
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = {zbps_pkg::SHADE_BG, sweep_depth_reg};
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(zbps_pkg::STORE_SIZE - 1)) begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_func)
                        zbps_pkg::FUNC_PLOT: state_next = ST_CALC;
                        zbps_pkg::FUNC_CLEAR: begin
                            sweep_depth_next = zbps_pkg::DEPTH_MIN;
                            state_next = ST_SWEEP;
                        end
                        zbps_pkg::FUNC_READ: begin
                            mem_re     = 1'b1;
                            mem_raddr  = s_read_addr[AW-1:0];
                            state_next = ST_RDOUT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CALC: begin
                if (!recip.busy && mul_cnt_reg == 3'd4) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                if (out_of_frame) begin
                    state_next = ST_IDLE;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_WR;
                end
            end
            ST_WR: begin
                mem_we     = (stored_depth < newd_reg);
                state_next = ST_IDLE;
            end
            ST_RDOUT: begin
                if (out_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    zbps_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && s_func == zbps_pkg::FUNC_PLOT),
        .zsum    (zs_in),
        .status  (recip)
    );

    zbps_ram #(
        .WIDTH (zbps_pkg::CELL_W),
        .DEPTH (zbps_pkg::STORE_SIZE)
    ) u_frame (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_SWEEP;
            sweep_reg       <= '0;
            sweep_depth_reg <= '0;
            out_valid_reg   <= 1'b0;
            mul_cnt_reg     <= '0;
            fw_reg          <= 8'd80;
            fh_reg          <= 7'd40;
            lx_reg          <= '0;
            ly_reg          <= '0;
            lz_reg          <= -16'sd16384;
        end else begin
            state_reg       <= state_next;
            sweep_reg       <= sweep_next;
            sweep_depth_reg <= sweep_depth_next;
            if (state_reg == ST_RDOUT && out_take) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept) begin
                mul_cnt_reg <= '0;
            end else if (state_reg == ST_CALC && mul_cnt_reg != 3'd4) begin
                mul_cnt_reg <= mul_cnt_reg + 3'd1;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    zbps_pkg::CFG_FRAME_WIDTH:  fw_reg <= cfg_wdata[7:0];
                    zbps_pkg::CFG_FRAME_HEIGHT: fh_reg <= cfg_wdata[6:0];
                    zbps_pkg::CFG_LIGHT_X:      lx_reg <= $signed(cfg_wdata);
                    zbps_pkg::CFG_LIGHT_Y:      ly_reg <= $signed(cfg_wdata);
                    zbps_pkg::CFG_LIGHT_Z:      lz_reg <= $signed(cfg_wdata);
                    default: ;
                endcase
            end
        end
        if (accept) begin
            sx_reg  <= sx_in;
            sy_reg  <= sy_in;
            nx_reg  <= s_norm_x;
            ny_reg  <= s_norm_y;
            nz_reg  <= s_norm_z;
            acc_reg <= '0;
        end else if (state_reg == ST_CALC) begin
            if (mul_cnt_reg < 3'd3) begin
                prod_reg <= mul_a * mul_b;
            end
            if (mul_cnt_reg != 3'd0 && mul_cnt_reg != 3'd4) begin
                acc_reg <= acc_reg + 36'(prod_reg);
            end
        end
        if (state_reg == ST_RD) begin
            idx_reg  <= idx;
            newd_reg <= recip.depth;
        end
        if (state_reg == ST_RDOUT && out_take) begin
            if (32'(s_read_addr) < 32'(zbps_pkg::STORE_SIZE)) begin
                out_shade_reg <= mem_rdata[19:16];
                out_depth_reg <= stored_depth;
            end else begin
                out_shade_reg <= zbps_pkg::SHADE_BG;
                out_depth_reg <= zbps_pkg::DEPTH_MIN;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pixel_shade = out_shade_reg;
    assign m_pixel_depth = out_depth_reg;

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_SWEEP || state_reg == ST_WR))
        else $error("frame store written outside sweep or write-back");
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_RDOUT)
        else $error("result raised without a read request");
    a_calc_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC && state_next == ST_RD) |-> !recip.busy)
        else $error("depth used before divider finished");
    a_no_accept_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> !s_ready)
        else $error("request taken during sweep");
endmodule
`default_nettype wire

FILE: tb/sv/tb_zbuffer_point_shader.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zbuffer_point_shader
// Self-checking bench for the z-buffer point shader. A queue of requests
// feeds a valid/ready driver; a shadow frame store predicts every pixel read,
// and a monitor checks each result against the oldest prediction. Runs
// several frame/light settings; all but one have random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_zbuffer_point_shader;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int SWEEP_WAIT = 8300;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASES = 6;
    localparam int PER_PHASE = 108;

    typedef struct {
        logic [1:0]         func;
        logic signed [15:0] vx, vy, vz, mx, my, mz, nx, ny, nz;
        logic [12:0]        addr;
    } request_t;

    typedef struct {
        logic [3:0]         shade;
        logic signed [15:0] depth;
    } pixel_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = '0;
    logic signed [15:0] s_vert_x = '0, s_vert_y = '0, s_vert_z = '0;
    logic signed [15:0] s_mesh_x = '0, s_mesh_y = '0, s_mesh_z = '0;
    logic signed [15:0] s_norm_x = '0, s_norm_y = '0, s_norm_z = '0;
    logic [12:0] s_read_addr = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [3:0] m_pixel_shade;
    logic signed [15:0] m_pixel_depth;

    zbuffer_point_shader dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_vert_x(s_vert_x), .s_vert_y(s_vert_y), .s_vert_z(s_vert_z),
        .s_mesh_x(s_mesh_x), .s_mesh_y(s_mesh_y), .s_mesh_z(s_mesh_z),
        .s_norm_x(s_norm_x), .s_norm_y(s_norm_y), .s_norm_z(s_norm_z),
        .s_read_addr(s_read_addr),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pixel_shade(m_pixel_shade), .m_pixel_depth(m_pixel_depth)
    );

    always #4 aclk = ~aclk;

    // shadow frame store and registers
    logic [3:0]         shade_mem [zbps_pkg::STORE_SIZE];
    logic signed [15:0] depth_mem [zbps_pkg::STORE_SIZE];
    int unsigned        frame_w, frame_h;
    longint             lx, ly, lz;

    request_t request_q[$];
    pixel_t   pixel_q[$];
    int       hot_q[$];
    int       fails = 0;
    int       cycles = 0;
    bit       calm_phase = 1'b0;

    function automatic int eff_w();
        return (frame_w > zbps_pkg::MAX_WIDTH) ? zbps_pkg::MAX_WIDTH : frame_w;
    endfunction

    function automatic int eff_h();
        return (frame_h > zbps_pkg::MAX_HEIGHT) ? zbps_pkg::MAX_HEIGHT : frame_h;
    endfunction

    function automatic logic signed [15:0] recip_depth(longint zs);
        longint q;
        if (zs == 0) return zbps_pkg::DEPTH_MAX;
        q = (longint'(1) << 20) / zs;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic logic [3:0] lit_shade(longint nx, longint ny, longint nz);
        longint dot, num, lvl;
        dot = nx * lx + ny * ly + nz * lz;
        num = ((longint'(1) << 28) - dot) * zbps_pkg::SHADE_LEVELS;
        if (num <= 0) return 4'd0;
        lvl = num >>> 29;
        if (lvl > zbps_pkg::SHADE_LEVELS - 1) lvl = zbps_pkg::SHADE_LEVELS - 1;
        return lvl[3:0];
    endfunction

    // update the shadow store for one accepted request
    function automatic void apply_request(request_t r);
        longint w, h, sx, sy;
        int idx;
        logic signed [15:0] d;
        pixel_t px;
        case (r.func)
            zbps_pkg::FUNC_PLOT: begin
                w = eff_w();
                h = eff_h();
                sx = longint'(r.vx) + r.mx + (w / 2) * 256;
                sy = longint'(r.vy) + r.my + (h / 2) * 512;
                if (sx >= 0 && sy >= 0 && sx < w * 256 && sy < h * 512) begin
                    idx = int'((sy >> 9) * w + (sx >> 8));
                    d = recip_depth(longint'(r.vz) + r.mz);
                    if (idx < zbps_pkg::STORE_SIZE && depth_mem[idx] < d) begin
                        depth_mem[idx] = d;
                        shade_mem[idx] = lit_shade(r.nx, r.ny, r.nz);
                    end
                end
            end
            zbps_pkg::FUNC_CLEAR: begin
                for (int i = 0; i < zbps_pkg::STORE_SIZE; i++) begin
                    shade_mem[i] = zbps_pkg::SHADE_BG;
                    depth_mem[i] = zbps_pkg::DEPTH_MIN;
                end
            end
            zbps_pkg::FUNC_READ: begin
                px.shade = shade_mem[r.addr];
                px.depth = depth_mem[r.addr];
                pixel_q.push_back(px);
            end
            default: ;
        endcase
    endfunction

    function automatic request_t blank(logic [1:0] f);
        request_t r;
        r.func = f;
        {r.vx, r.vy, r.vz, r.mx, r.my, r.mz, r.nx, r.ny, r.nz} = '0;
        r.addr = '0;
        return r;
    endfunction

    // split a sum into vertex and mesh parts, both within 16 bits
    task automatic split(input longint t, output logic signed [15:0] a,
                         output logic signed [15:0] b);
        longint m, v;
        m = longint'($signed(16'($urandom)));
        v = t - m;
        if (v < -32768 || v > 32767) begin
            m = 0;
            v = t;
        end
        a = v[15:0];
        b = m[15:0];
    endtask

    function automatic logic signed [15:0] rand_norm();
        return 16'($urandom_range(32768) - 16384);
    endfunction

    function automatic longint rand_zsum();
        case ($urandom_range(9))
            0: return 0;
            1: return longint'($urandom_range(65535)) - 32768;
            2, 3: return -longint'($urandom_range(4000, 1));
            default: return longint'($urandom_range(4000, 1));
        endcase
    endfunction

    task automatic aimed_plot(input int col, input int row, input longint zs,
                              output request_t r);
        r = blank(zbps_pkg::FUNC_PLOT);
        split(longint'(col) * 256 + $urandom_range(255) - (eff_w() / 2) * 256,
              r.vx, r.mx);
        split(longint'(row) * 512 + $urandom_range(511) - (eff_h() / 2) * 512,
              r.vy, r.my);
        split(zs, r.vz, r.mz);
        r.nx = rand_norm();
        r.ny = rand_norm();
        r.nz = rand_norm();
    endtask

    task automatic random_request(output request_t r);
        int sel, col, row, pick;
        sel = $urandom_range(99);
        if (sel < 60 && eff_w() > 0 && eff_h() > 0) begin
            if (hot_q.size() > 0 && $urandom_range(1)) begin
                pick = hot_q[$urandom_range(hot_q.size() - 1)];
                col = pick % eff_w();
                row = pick / eff_w();
            end else begin
                col = $urandom_range(eff_w() - 1);
                row = $urandom_range(eff_h() - 1);
                hot_q.push_back(row * eff_w() + col);
                if (hot_q.size() > 12) void'(hot_q.pop_front());
            end
            aimed_plot(col, row, rand_zsum(), r);
        end else if (sel < 70) begin
            r = blank(zbps_pkg::FUNC_PLOT);
            {r.vx, r.vy, r.vz, r.mx, r.my, r.mz} = {$urandom, $urandom, $urandom};
            r.nx = rand_norm();
            r.ny = rand_norm();
            r.nz = rand_norm();
        end else if (sel < 95) begin
            r = blank(zbps_pkg::FUNC_READ);
            if (hot_q.size() > 0 && $urandom_range(3) != 0)
                r.addr = 13'(hot_q[$urandom_range(hot_q.size() - 1)]);
            else
                r.addr = 13'($urandom);
        end else if (sel < 98) begin
            r = blank(FUNC_NONE);
            r.addr = 13'($urandom);
        end else begin
            r = blank(zbps_pkg::FUNC_CLEAR);
        end
    endtask

    task automatic write_regs(input int w, input int h, input int x, input int y,
                              input int z);
        logic [15:0] vals [5];
        vals = '{16'(w), 16'(h), 16'(x), 16'(y), 16'(z)};
        for (int i = 0; i < 5; i++) begin
            @(posedge aclk);
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= vals[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        frame_w = w & 8'hff;
        frame_h = h & 7'h7f;
        lx = longint'($signed(16'(x)));
        ly = longint'($signed(16'(y)));
        lz = longint'($signed(16'(z)));
    endtask

    task automatic wait_drained();
        while (request_q.size() > 0 || s_valid || pixel_q.size() > 0)
            @(posedge aclk);
        // a clear produces nothing, so let any sweep finish
        repeat (SWEEP_WAIT) @(posedge aclk);
    endtask

    function automatic int pick_gap();
        int p;
        if (calm_phase) return 0;
        p = $urandom_range(99);
        if (p < 40) return 0;
        if (p < 85) return $urandom_range(3, 1);
        if (p < 97) return $urandom_range(15, 4);
        return $urandom_range(60, 20);
    endfunction

    // request driver
    int gap = 0;
    request_t cur;
    always @(posedge aclk) begin
        logic busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                apply_request(cur);
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap > 0) begin
                    gap--;
                end else if (request_q.size() > 0) begin
                    cur = request_q.pop_front();
                    busy = 1'b1;
                    s_func <= cur.func;
                    s_vert_x <= cur.vx;
                    s_vert_y <= cur.vy;
                    s_vert_z <= cur.vz;
                    s_mesh_x <= cur.mx;
                    s_mesh_y <= cur.my;
                    s_mesh_z <= cur.mz;
                    s_norm_x <= cur.nx;
                    s_norm_y <= cur.ny;
                    s_norm_z <= cur.nz;
                    s_read_addr <= cur.addr;
                    gap = pick_gap();
                end
            end
            s_valid <= busy;
        end
    end

    // result monitor
    int stall = 0;
    always @(posedge aclk) begin
        pixel_t want;
        logic rdy;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result shade=%0d depth=%0d",
                                 m_pixel_shade, m_pixel_depth);
                end else begin
                    want = pixel_q.pop_front();
                    if (want.shade !== m_pixel_shade || want.depth !== m_pixel_depth) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: shade exp %0d got %0d, depth exp %0d got %0d",
                                     want.shade, m_pixel_shade, want.depth, m_pixel_depth);
                    end
                end
            end
            rdy = (stall == 0);
            if (stall > 0) stall--;
            else stall = pick_gap();
            m_ready <= rdy;
        end
    end

    initial begin
        request_t r;
        for (int i = 0; i < zbps_pkg::STORE_SIZE; i++) begin
            shade_mem[i] = zbps_pkg::SHADE_BG;
            depth_mem[i] = '0;
        end
        frame_w = 80;
        frame_h = 40;
        lx = 0;
        ly = 0;
        lz = -16384;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: write_regs(128, 64, 16384, 0, 0);
                2: write_regs(1, 1, -16384, 16384, 16384);
                3: write_regs(255, 127, $urandom_range(32768) - 16384,
                              $urandom_range(32768) - 16384, -16384);
                4: write_regs(0, 0, 11585, -11585, 0);
                5: write_regs(37, 21, $urandom_range(32768) - 16384,
                              $urandom_range(32768) - 16384,
                              $urandom_range(32768) - 16384);
                default: write_regs(80, 40, 0, 0, -16384);
            endcase
            calm_phase = (p == 2);
            hot_q.delete();
            if (p == 0) begin
                // untouched pixels, then depth saturation and shade extremes
                r = blank(zbps_pkg::FUNC_READ);
                request_q.push_back(r);
                r.addr = 13'h1fff;
                request_q.push_back(r);
                aimed_plot(40, 20, 0, r);
                r.nx = 0; r.ny = 0; r.nz = 16384;
                request_q.push_back(r);
                aimed_plot(40, 20, 100, r);
                request_q.push_back(r);
                r = blank(zbps_pkg::FUNC_READ);
                r.addr = 13'(20 * 80 + 40);
                request_q.push_back(r);
                aimed_plot(0, 0, 32767, r);
                r.nx = 0; r.ny = 0; r.nz = -16384;
                request_q.push_back(r);
                aimed_plot(79, 39, -1, r);
                request_q.push_back(r);
                r = blank(zbps_pkg::FUNC_READ);
                request_q.push_back(r);
                r.addr = 13'(39 * 80 + 79);
                request_q.push_back(r);
                r = blank(zbps_pkg::FUNC_PLOT);
                {r.vx, r.vy, r.vz, r.mx, r.my, r.mz} = {6{16'sh8000}};
                {r.nx, r.ny, r.nz} = {3{-16'sd16384}};
                request_q.push_back(r);
                {r.vx, r.vy, r.vz, r.mx, r.my, r.mz} = {6{16'sh7fff}};
                {r.nx, r.ny, r.nz} = {3{16'sd16384}};
                request_q.push_back(r);
                r = blank(FUNC_NONE);
                r.addr = 13'h1fff;
                request_q.push_back(r);
                request_q.push_back(blank(zbps_pkg::FUNC_CLEAR));
                r = blank(zbps_pkg::FUNC_READ);
                r.addr = 13'(20 * 80 + 40);
                request_q.push_back(r);
                aimed_plot(40, 20, -100, r);
                request_q.push_back(r);
                aimed_plot(40, 20, -32768, r);
                request_q.push_back(r);
                r = blank(zbps_pkg::FUNC_READ);
                r.addr = 13'(20 * 80 + 40);
                request_q.push_back(r);
            end
            for (int i = 0; i < PER_PHASE; i++) begin
                random_request(r);
                request_q.push_back(r);
            end
            // finish each phase on a read so the store is idle when drained
            r = blank(zbps_pkg::FUNC_READ);
            r.addr = 13'($urandom);
            request_q.push_back(r);
            wait_drained();
        end

        if (fails == 0 && pixel_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

FILE: sim.f
sv/zbps_pkg.sv
sv/zbps_ram.sv
sv/zbps_recip.sv
sv/zbuffer_point_shader.sv
tb/sv/tb_zbuffer_point_shader.sv
